// ----- rtl/hcbd_pkg.sv -----
// shared types, constants and byte classifiers for the chunked body deframer
// no dependencies; imported by every module of the block
package hcbd_pkg;

    localparam int unsigned SIZE_BITS_DEF = 32;
    localparam logic [4:0]  KEY_LEN       = 5'd26;
    localparam logic [7:0]  CHAR_LF       = 8'h0A;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [1:0]  TRAILER_LEN   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_PLAIN   = 3'd1,
        PH_SIZE    = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_ENDED   = 3'd5
    } t_phase;

    typedef struct packed {
        logic clear;
        logic step;
    } t_hdr_cmd;

    typedef struct packed {
        logic chunked;
        logic blank_line;
    } t_hdr_stat;

    typedef struct packed {
        logic clear;
        logic reset_size;
        logic size_step;
        logic data_step;
        logic trailer_step;
    } t_chunk_cmd;

    typedef struct packed {
        logic left_zero;
        logic left_one;
        logic trailer_done;
    } t_chunk_stat;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        return (c >= "0" && c <= "9") || (l >= "a" && l <= "f");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (c >= "0" && c <= "9") begin
            return 4'(c - "0");
        end
        return 4'(l - "a" + 8'd10);
    endfunction

    // lower-case key "transfer-encoding: chunked"
    function automatic logic [7:0] key_lc(input logic [4:0] pos);
        logic [7:0] k;
        case (pos)
            5'd0:    k = "t";
            5'd1:    k = "r";
            5'd2:    k = "a";
            5'd3:    k = "n";
            5'd4:    k = "s";
            5'd5:    k = "f";
            5'd6:    k = "e";
            5'd7:    k = "r";
            5'd8:    k = "-";
            5'd9:    k = "e";
            5'd10:   k = "n";
            5'd11:   k = "c";
            5'd12:   k = "o";
            5'd13:   k = "d";
            5'd14:   k = "i";
            5'd15:   k = "n";
            5'd16:   k = "g";
            5'd17:   k = ":";
            5'd18:   k = " ";
            5'd19:   k = "c";
            5'd20:   k = "h";
            5'd21:   k = "u";
            5'd22:   k = "n";
            5'd23:   k = "k";
            5'd24:   k = "e";
            5'd25:   k = "d";
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/hcbd_hdr.sv -----
// header line tracker: trims blanks and matches the transfer-encoding key
// depends on hcbd_pkg
module hcbd_hdr
    import hcbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_hdr_cmd   i_cmd,
    input  logic [7:0] i_byte,
    output t_hdr_stat  o_stat
);

    logic [4:0] r_pos, n_pos;
    logic       r_nonempty, n_nonempty;
    logic       r_mismatch, n_mismatch;
    logic       r_oddblank, n_oddblank;
    logic [7:0] r_blanks, n_blanks;
    logic       r_chunked, n_chunked;

    logic [4:0] w_p1;
    logic       w_m1;
    logic       w_ok1, w_ok2;

    always_comb begin
        n_pos      = r_pos;
        n_nonempty = r_nonempty;
        n_mismatch = r_mismatch;
        n_oddblank = r_oddblank;
        n_blanks   = r_blanks;
        n_chunked  = r_chunked;
        w_p1       = r_pos;
        w_m1       = r_mismatch;
        w_ok1      = (r_pos < KEY_LEN) && (key_lc(r_pos) == CHAR_SPACE);
        w_ok2      = 1'b0;

        if (i_cmd.clear) begin
            n_pos      = '0;
            n_nonempty = 1'b0;
            n_mismatch = 1'b0;
            n_oddblank = 1'b0;
            n_blanks   = '0;
            n_chunked  = 1'b0;
        end else if (i_cmd.step) begin
            if (i_byte == CHAR_LF) begin
                if (r_nonempty && !r_mismatch && r_pos == KEY_LEN) begin
                    n_chunked = 1'b1;
                end
                n_pos      = '0;
                n_nonempty = 1'b0;
                n_mismatch = 1'b0;
                n_oddblank = 1'b0;
                n_blanks   = '0;
            end else if (is_blank(i_byte)) begin
                if (r_nonempty) begin
                    if (r_blanks != 8'hFF) begin
                        n_blanks = r_blanks + 8'd1;
                    end
                    if (i_byte != CHAR_SPACE) begin
                        n_oddblank = 1'b1;
                    end
                end
            end else begin
                // inner blanks must be exactly the single key space
                if (!r_mismatch && r_blanks != 8'd0) begin
                    if (r_blanks == 8'd1 && !r_oddblank && w_ok1) begin
                        w_p1 = r_pos + 5'd1;
                    end else begin
                        w_m1 = 1'b1;
                    end
                end
                w_ok2      = (w_p1 < KEY_LEN) && (key_lc(w_p1) == to_lower(i_byte));
                n_blanks   = '0;
                n_oddblank = 1'b0;
                n_nonempty = 1'b1;
                n_pos      = w_p1;
                n_mismatch = w_m1;
                if (!w_m1) begin
                    if (w_ok2) begin
                        n_pos = w_p1 + 5'd1;
                    end else begin
                        n_mismatch = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_nonempty <= 1'b0;
            r_mismatch <= 1'b0;
            r_oddblank <= 1'b0;
            r_blanks   <= '0;
            r_chunked  <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_nonempty <= n_nonempty;
            r_mismatch <= n_mismatch;
            r_oddblank <= n_oddblank;
            r_blanks   <= n_blanks;
            r_chunked  <= n_chunked;
        end
    end

    assign o_stat.chunked    = r_chunked;
    assign o_stat.blank_line = (i_byte == CHAR_LF) && !r_nonempty;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= KEY_LEN)
        else $error("key position past key length");

    a_blank_needs_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blanks != 8'd0 |-> r_nonempty)
        else $error("pending blanks counted on an empty line");

    a_clear_line_at_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && !i_cmd.clear && i_byte == CHAR_LF |=>
            r_pos == 5'd0 && !r_nonempty && !r_mismatch && r_blanks == 8'd0)
        else $error("line state not cleared at line end");

endmodule

// ----- rtl/hcbd_chunk.sv -----
// chunk size parser, data byte counter and trailer skip counter
// depends on hcbd_pkg
module hcbd_chunk
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chunk_cmd  i_cmd,
    input  logic [7:0]  i_byte,
    output t_chunk_stat o_stat
);

    logic [SIZE_BITS-1:0] r_left, n_left;
    logic                 r_started, n_started;
    logic                 r_stopped, n_stopped;
    logic [1:0]           r_trailer, n_trailer;

    always_comb begin
        n_left    = r_left;
        n_started = r_started;
        n_stopped = r_stopped;
        n_trailer = r_trailer;

        if (i_cmd.clear) begin
            n_left    = '0;
            n_started = 1'b0;
            n_stopped = 1'b0;
            n_trailer = '0;
        end else if (i_cmd.reset_size) begin
            n_left    = '0;
            n_started = 1'b0;
            n_stopped = 1'b0;
        end else if (i_cmd.size_step) begin
            if (i_byte == CHAR_LF) begin
                n_started = 1'b0;
                n_stopped = 1'b0;
            end else if (!r_stopped && !(!r_started && is_blank(i_byte))) begin
                n_started = 1'b1;
                if (!hex_ok(i_byte)) begin
                    n_stopped = 1'b1;
                end else if (|r_left[SIZE_BITS-1 -: 4]) begin
                    n_left = '1;
                end else begin
                    n_left = {r_left[SIZE_BITS-5:0], hex_val(i_byte)};
                end
            end
        end else if (i_cmd.data_step) begin
            n_left = r_left - {{(SIZE_BITS-1){1'b0}}, 1'b1};
            if (r_left == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
                n_trailer = TRAILER_LEN;
            end
        end else if (i_cmd.trailer_step) begin
            if (r_trailer != 2'd0) begin
                n_trailer = r_trailer - 2'd1;
            end
            if (r_trailer <= 2'd1) begin
                n_left    = '0;
                n_started = 1'b0;
                n_stopped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_started <= 1'b0;
            r_stopped <= 1'b0;
            r_trailer <= '0;
        end else begin
            r_left    <= n_left;
            r_started <= n_started;
            r_stopped <= n_stopped;
            r_trailer <= n_trailer;
        end
    end

    assign o_stat.left_zero    = (r_left == '0);
    assign o_stat.left_one     = (r_left == {{(SIZE_BITS-1){1'b0}}, 1'b1});
    assign o_stat.trailer_done = (r_trailer <= 2'd1);

    a_stop_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_started)
        else $error("size parse stopped without starting");

    a_trailer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trailer <= TRAILER_LEN)
        else $error("trailer count out of range");

    a_last_data_loads_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.data_step && !i_cmd.clear && !i_cmd.reset_size && !i_cmd.size_step
            && r_left == {{(SIZE_BITS-1){1'b0}}, 1'b1}
        |=> r_trailer == TRAILER_LEN && r_left == '0)
        else $error("last data byte did not arm the trailer skip");

endmodule

// ----- rtl/http_chunked_body_deframer.sv -----
// HTTP/1.1 response body deframer: takes one received byte per item, parses the
// header lines, then passes body bytes out, removing chunked framing when the
// transfer-encoding header asks for it. A zero-size chunk yields one end item
// (stream_end set, byte zero) and later bytes are dropped until new_connection.
// Throughput is one item per cycle: each byte goes from the input register through
// a single pass of phase, header and chunk-counter logic into the result register,
// so a result is registered as its input item leaves the input register. Items
// that produce no result (header bytes, size lines, trailers) are absorbed without
// a bubble, but any item waits while an earlier result is held by the receiver.
// depends on hcbd_pkg, hcbd_hdr, hcbd_chunk
module http_chunked_body_deframer
    import hcbd_pkg::*;
#(
    parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_new_connection,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_stream_end
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_newconn;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    t_phase      r_phase, n_phase;
    t_hdr_cmd    w_hdr_cmd;
    t_hdr_stat   w_hdr_stat;
    t_chunk_cmd  w_chunk_cmd;
    t_chunk_stat w_chunk_stat;

    logic       w_consume;
    logic       w_has_res;
    logic [7:0] w_res_byte;
    logic       w_res_end;

    assign w_consume  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_in_byte;
            r_in_newconn <= i_new_connection;
        end
    end

    hcbd_hdr u_hdr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_hdr_cmd),
        .i_byte  (r_in_byte),
        .o_stat  (w_hdr_stat)
    );

    hcbd_chunk #(
        .SIZE_BITS (SIZE_BITS)
    ) u_chunk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_chunk_cmd),
        .i_byte  (r_in_byte),
        .o_stat  (w_chunk_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        w_hdr_cmd   = '0;
        w_chunk_cmd = '0;
        w_has_res   = 1'b0;
        w_res_byte  = r_in_byte;
        w_res_end   = 1'b0;

        if (w_consume) begin
            if (r_in_newconn) begin
                n_phase           = PH_HEADER;
                w_hdr_cmd.clear   = 1'b1;
                w_chunk_cmd.clear = 1'b1;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        w_hdr_cmd.step = 1'b1;
                        if (w_hdr_stat.blank_line) begin
                            n_phase                = w_hdr_stat.chunked ? PH_SIZE : PH_PLAIN;
                            w_chunk_cmd.reset_size = 1'b1;
                        end
                    end
                    PH_PLAIN: begin
                        w_has_res = 1'b1;
                    end
                    PH_SIZE: begin
                        w_chunk_cmd.size_step = 1'b1;
                        if (r_in_byte == CHAR_LF) begin
                            if (w_chunk_stat.left_zero) begin
                                n_phase    = PH_ENDED;
                                w_has_res  = 1'b1;
                                w_res_byte = 8'h00;
                                w_res_end  = 1'b1;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        w_chunk_cmd.data_step = 1'b1;
                        w_has_res             = 1'b1;
                        if (w_chunk_stat.left_one) begin
                            n_phase = PH_TRAILER;
                        end
                    end
                    PH_TRAILER: begin
                        w_chunk_cmd.trailer_step = 1'b1;
                        if (w_chunk_stat.trailer_done) begin
                            n_phase = PH_SIZE;
                        end
                    end
                    PH_ENDED: begin
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume) begin
            r_out_valid <= w_has_res;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_consume && w_has_res) begin
            r_out_byte <= w_res_byte;
            r_out_end  <= w_res_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_stream_end   = r_out_end;

    a_end_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_end |-> o_payload_byte == 8'h00)
        else $error("end item carries a non-zero byte");

    a_newconn_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && r_in_newconn |=> r_phase == PH_HEADER && !o_out_valid)
        else $error("new connection did not restart at header phase");

    a_end_enters_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && w_has_res && w_res_end |=> r_phase == PH_ENDED && o_stream_end)
        else $error("end item without ended phase");

    a_no_result_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && (r_phase == PH_HEADER || r_phase == PH_ENDED
            || r_phase == PH_TRAILER) |-> !w_has_res)
        else $error("result produced in a phase that emits none");

endmodule
